### hdl/vrt_pkg.sv
`timescale 1ns / 1ps

package vrt_pkg;

  // internal fixed-point format: signed, 28 fraction bits
  localparam int INT_FRAC = 28;
  localparam int IDX_W = 14;

  // ratio divider: 31 quotient bits, value limited to 4.0
  localparam int DIV_STEPS = 31;
  localparam int N_W = 31;
  localparam logic [N_W-1:0] N_LIMIT = N_W'(1) << (INT_FRAC + 2);

  // square root: 62-bit radicand, 31-bit root
  localparam int RAD_W = 62;
  localparam int ROOT_W = 31;
  localparam int REM_W = 32;

  typedef logic signed [31:0] q_t;   // |value| <= 4.0
  typedef logic signed [33:0] qw_t;  // |value| <= 16.0
  typedef logic signed [39:0] qr_t;  // wide intermediate

  localparam logic signed [63:0] Q_ONE = 64'sd1 <<< INT_FRAC;

  // items travelling alongside the ratio divider
  typedef struct packed {
    q_t [2:0] d;
    q_t [2:0] m;
    q_t       c;
    q_t       omc;
  } div_side_t;

  // items travelling alongside the square root
  typedef struct packed {
    q_t  [2:0] m;
    qw_t [2:0] nd;
    qr_t [2:0] mir;
    qw_t       nc;
    logic      cpos;
    logic      tir;
  } sq_side_t;

endpackage

### hdl/vrt_if.sv
`timescale 1ns / 1ps

interface vrt_ray_if #(parameter int VEC_WIDTH = 16);
  logic                              valid;
  logic                              ready;
  logic signed [VEC_WIDTH-1:0]       ray_x;
  logic signed [VEC_WIDTH-1:0]       ray_y;
  logic signed [VEC_WIDTH-1:0]       ray_z;
  logic signed [VEC_WIDTH-1:0]       normal_x;
  logic signed [VEC_WIDTH-1:0]       normal_y;
  logic signed [VEC_WIDTH-1:0]       normal_z;
  logic        [vrt_pkg::IDX_W-1:0]  index_from;
  logic        [vrt_pkg::IDX_W-1:0]  index_to;

  modport source (output valid, ray_x, ray_y, ray_z, normal_x, normal_y, normal_z,
                  index_from, index_to, input ready);
  modport sink (input valid, ray_x, ray_y, ray_z, normal_x, normal_y, normal_z,
                index_from, index_to, output ready);
endinterface

interface vrt_result_if #(parameter int VEC_WIDTH = 16);
  logic                        valid;
  logic                        ready;
  logic signed [VEC_WIDTH-1:0] out_x;
  logic signed [VEC_WIDTH-1:0] out_y;
  logic signed [VEC_WIDTH-1:0] out_z;
  logic                        total_reflection;

  modport source (output valid, out_x, out_y, out_z, total_reflection, input ready);
  modport sink (input valid, out_x, out_y, out_z, total_reflection, output ready);
endinterface

### hdl/vrt_div.sv
`timescale 1ns / 1ps

module vrt_div #(
  parameter int SIDE_W = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [vrt_pkg::IDX_W-1:0]    num,
  input  logic [vrt_pkg::IDX_W-1:0]    den,
  input  logic [SIDE_W-1:0]            in_side,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [vrt_pkg::N_W-1:0]      quo,
  output logic [SIDE_W-1:0]            out_side
);

  localparam int NS = vrt_pkg::DIV_STEPS + 1;
  localparam int IW = vrt_pkg::IDX_W;
  localparam int QB = vrt_pkg::N_W;

  logic            v    [NS];
  logic            en   [NS];
  logic            ovf  [NS];
  logic [IW-1:0]   rem  [NS];
  logic [IW-1:0]   dv   [NS];
  logic [QB-1:0]   q    [NS];
  logic [QB-1:0]   nb   [NS];
  logic [SIDE_W-1:0] side [NS];

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int j = NS - 2; j >= 0; j--) begin
      en[j] = !v[j] || en[j+1];
    end
  end

  assign in_ready = en[0];

  // entry: quotient overflows 31 bits when num >= 8 * den
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      ovf[0]  <= ({3'b000, num} >= {den, 3'b000});
      rem[0]  <= IW'(num >> 3);
      dv[0]   <= den;
      q[0]    <= '0;
      nb[0]   <= {num[2:0], (QB - 3)'(0)};
      side[0] <= in_side;
    end
  end

  // one restoring quotient bit per stage
  for (genvar j = 1; j < NS; j++) begin : g_step
    logic [IW:0] trial;
    logic        ge;

    always_comb begin
      trial = {rem[j-1], nb[j-1][QB-1]};
      ge    = (trial >= {1'b0, dv[j-1]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en[j]) begin
        v[j] <= v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[j] && v[j-1]) begin
        ovf[j]  <= ovf[j-1];
        rem[j]  <= ge ? IW'(trial - {1'b0, dv[j-1]}) : IW'(trial);
        dv[j]   <= dv[j-1];
        q[j]    <= {q[j-1][QB-2:0], ge};
        nb[j]   <= {nb[j-1][QB-2:0], 1'b0};
        side[j] <= side[j-1];
      end
    end
  end

  assign out_valid = v[NS-1];
  assign out_side  = side[NS-1];
  assign quo = (ovf[NS-1] || (q[NS-1] > vrt_pkg::N_LIMIT)) ? vrt_pkg::N_LIMIT : q[NS-1];

endmodule

### hdl/vrt_sqrt.sv
`timescale 1ns / 1ps

module vrt_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vrt_pkg::RAD_W-1:0]     rad,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vrt_pkg::ROOT_W-1:0]    root,
  output logic [SIDE_W-1:0]             out_side
);

  localparam int NS = vrt_pkg::ROOT_W + 1;
  localparam int RW = vrt_pkg::RAD_W;
  localparam int TW = vrt_pkg::ROOT_W;
  localparam int MW = vrt_pkg::REM_W;

  logic              v    [NS];
  logic              en   [NS];
  logic [MW-1:0]     rem  [NS];
  logic [TW-1:0]     rt   [NS];
  logic [RW-1:0]     rr   [NS];
  logic [SIDE_W-1:0] side [NS];

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int j = NS - 2; j >= 0; j--) begin
      en[j] = !v[j] || en[j+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      rem[0]  <= '0;
      rt[0]   <= '0;
      rr[0]   <= rad;
      side[0] <= in_side;
    end
  end

  // one root bit per stage, two radicand bits consumed
  for (genvar j = 1; j < NS; j++) begin : g_step
    logic [MW+1:0] part;
    logic [MW+1:0] trial;
    logic          ge;

    always_comb begin
      part  = {rem[j-1], rr[j-1][RW-1:RW-2]};
      trial = (MW + 2)'({rt[j-1], 2'b01});
      ge    = (part >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en[j]) begin
        v[j] <= v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[j] && v[j-1]) begin
        rem[j]  <= ge ? MW'(part - trial) : MW'(part);
        rt[j]   <= {rt[j-1][TW-2:0], ge};
        rr[j]   <= {rr[j-1][RW-3:0], 2'b00};
        side[j] <= side[j-1];
      end
    end
  end

  assign out_valid = v[NS-1];
  assign root      = rt[NS-1];
  assign out_side  = side[NS-1];

endmodule

### hdl/vector_refraction_with_tir.sv
`timescale 1ns / 1ps

// Snell refraction of a ray direction at a face, with total internal reflection.
// Each item carries a ray direction and face normal (signed Q1.(VEC_WIDTH-2)) and
// the indices of the two media (unsigned Q2.12). The block returns the refracted
// direction, or the mirror direction with total_reflection set when the
// discriminant is not positive or the cosine is zero; components are rounded and
// saturated. A fully pipelined datapath takes one item every cycle unless the
// result side stalls; each item passes through the 32-stage ratio divider and
// the 32-stage square root plus 10 arithmetic stages. Stalls on the result side
// back up stage by stage, so bubbles are absorbed before input stalls.
module vector_refraction_with_tir #(
  parameter int VEC_WIDTH = 16
) (
  input logic           clk,
  input logic           rst,
  vrt_ray_if.sink       ray,
  vrt_result_if.source  result
);

  localparam int FRAC = VEC_WIDTH - 2;
  // left shift into the internal format, or floor right shift when finer
  localparam int FL = (FRAC < vrt_pkg::INT_FRAC) ? vrt_pkg::INT_FRAC - FRAC : 0;
  localparam int FR = (FRAC > vrt_pkg::INT_FRAC) ? FRAC - vrt_pkg::INT_FRAC : 0;
  localparam logic signed [47:0] RND = (FL > 0) ? (48'sd1 <<< ((FL > 0) ? FL - 1 : 0))
                                                : 48'sd0;
  localparam logic signed [47:0] OUT_HI = (48'sd1 <<< (VEC_WIDTH - 1)) - 48'sd1;
  localparam logic signed [47:0] OUT_LO = -(48'sd1 <<< (VEC_WIDTH - 1));
  localparam logic signed [33:0] C_MAX = 34'sd1 <<< (vrt_pkg::INT_FRAC + 1);

  // fixed-point product, floored back to the internal format
  function automatic logic signed [63:0] mulq(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p >>> vrt_pkg::INT_FRAC;
  endfunction

  function automatic vrt_pkg::q_t to_q(input logic [VEC_WIDTH-1:0] raw);
    logic signed [VEC_WIDTH-1:0] s;
    s = $signed(raw);
    return (32'(s) <<< FL) >>> FR;
  endfunction

  // stage enables: a stage moves when empty or when the next one moves
  logic en1, en2, en3, en4, en_b1, en_b2, en_b3, en_c1, en_c2, en_c3;
  logic div_in_ready, div_out_valid, sq_in_ready, sq_out_valid;
  logic v_b1, v_b2, v_b3;
  logic v_c1, v_c2, v_c3;

  // ---------------- front: convert, dot product, cosine terms ----------------
  logic v1, v2, v3, v4;
  vrt_pkg::q_t d1 [3], m1 [3], d2 [3], m2 [3], p2 [3], d3 [3], m3 [3];
  logic [vrt_pkg::IDX_W-1:0] n0_1, n1_1, n0_2, n1_2, n0_3, n1_3, n0_4, n1_4;
  vrt_pkg::q_t c3;
  vrt_pkg::div_side_t side4;

  always_comb begin
    en_c3 = !v_c3 || result.ready;
    en_c2 = !v_c2 || en_c3;
    en_c1 = !v_c1 || en_c2;
    en_b3 = !v_b3 || sq_in_ready;
    en_b2 = !v_b2 || en_b3;
    en_b1 = !v_b1 || en_b2;
    en4   = !v4 || div_in_ready;
    en3   = !v3 || en4;
    en2   = !v2 || en3;
    en1   = !v1 || en2;
  end

  assign ray.ready = en1;

  // stage 1: capture and widen into the internal format
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= ray.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && ray.valid) begin
      d1[0] <= to_q(ray.ray_x);
      d1[1] <= to_q(ray.ray_y);
      d1[2] <= to_q(ray.ray_z);
      m1[0] <= to_q(ray.normal_x);
      m1[1] <= to_q(ray.normal_y);
      m1[2] <= to_q(ray.normal_z);
      n0_1  <= ray.index_from;
      n1_1  <= ray.index_to;
    end
  end

  // stage 2: per-axis products of the dot product
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      for (int i = 0; i < 3; i++) begin
        p2[i] <= 32'(mulq(d1[i], m1[i]));
        d2[i] <= d1[i];
        m2[i] <= m1[i];
      end
      n0_2 <= n0_1;
      n1_2 <= n1_1;
    end
  end

  // stage 3: sum and clamp the cosine to [-2, 2]
  logic signed [33:0] csum;
  always_comb begin
    csum = 34'(p2[0]) + 34'(p2[1]) + 34'(p2[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      priority if (csum > C_MAX) begin
        c3 <= 32'(C_MAX);
      end else if (csum < -C_MAX) begin
        c3 <= 32'(-C_MAX);
      end else begin
        c3 <= 32'(csum);
      end
      for (int i = 0; i < 3; i++) begin
        d3[i] <= d2[i];
        m3[i] <= m2[i];
      end
      n0_3 <= n0_2;
      n1_3 <= n1_2;
    end
  end

  // stage 4: one minus cosine squared
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      for (int i = 0; i < 3; i++) begin
        side4.d[i] <= d3[i];
        side4.m[i] <= m3[i];
      end
      side4.c   <= c3;
      side4.omc <= 32'(vrt_pkg::Q_ONE - mulq(c3, c3));
      n0_4      <= n0_3;
      n1_4      <= n1_3;
    end
  end

  // ---------------- index ratio ----------------
  logic [vrt_pkg::N_W-1:0] ratio;
  vrt_pkg::div_side_t      side_d;

  vrt_div #(
    .SIDE_W ($bits(vrt_pkg::div_side_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_ready  (div_in_ready),
    .num       (n0_4),
    .den       (n1_4),
    .in_side   (side4),
    .out_valid (div_out_valid),
    .out_ready (en_b1),
    .quo       (ratio),
    .out_side  (side_d)
  );

  // ---------------- discriminant ----------------
  logic signed [63:0] n_s;
  logic signed [63:0] two_c;
  vrt_pkg::qw_t nn_b1, nc_b1, nc_b2, nd_b1 [3], nd_b2 [3];
  vrt_pkg::qr_t mir_b1 [3], mir_b2 [3], t_b2;
  vrt_pkg::q_t  m_b1 [3], m_b2 [3], c_b1, c_b2, omc_b1;
  vrt_pkg::sq_side_t side_b3;
  logic [vrt_pkg::RAD_W-1:0] rad_b3;
  vrt_pkg::qr_t k_b3;
  logic tir_b3;

  always_comb begin
    n_s   = $signed(64'(ratio));
    two_c = 64'($signed(side_d.c)) * 64'sd2;
  end

  // stage b1: products with the ratio, and the mirror direction
  always_ff @(posedge clk) begin
    if (rst) begin
      v_b1 <= 1'b0;
    end else if (en_b1) begin
      v_b1 <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b1 && div_out_valid) begin
      nn_b1 <= 34'(mulq(n_s, n_s));
      nc_b1 <= 34'(mulq(n_s, $signed(side_d.c)));
      for (int i = 0; i < 3; i++) begin
        nd_b1[i]  <= 34'(mulq(n_s, $signed(side_d.d[i])));
        mir_b1[i] <= 40'($signed(side_d.d[i])) - 40'(mulq(two_c, $signed(side_d.m[i])));
        m_b1[i]   <= $signed(side_d.m[i]);
      end
      c_b1   <= $signed(side_d.c);
      omc_b1 <= $signed(side_d.omc);
    end
  end

  // stage b2: n^2 times (1 - c^2)
  always_ff @(posedge clk) begin
    if (rst) begin
      v_b2 <= 1'b0;
    end else if (en_b2) begin
      v_b2 <= v_b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b2 && v_b1) begin
      t_b2  <= 40'(mulq(nn_b1, omc_b1));
      nc_b2 <= nc_b1;
      c_b2  <= c_b1;
      for (int i = 0; i < 3; i++) begin
        nd_b2[i]  <= nd_b1[i];
        mir_b2[i] <= mir_b1[i];
        m_b2[i]   <= m_b1[i];
      end
    end
  end

  // stage b3: k and the reflection decision; radicand is k in Q.56
  always_comb begin
    k_b3   = 40'(vrt_pkg::Q_ONE) - t_b2;
    tir_b3 = (c_b2 == '0) || (k_b3 <= 40'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b3 <= 1'b0;
    end else if (en_b3) begin
      v_b3 <= v_b2;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b3 && v_b2) begin
      rad_b3 <= tir_b3 ? '0 : {k_b3[vrt_pkg::RAD_W-vrt_pkg::INT_FRAC-1:0],
                               vrt_pkg::INT_FRAC'(0)};
      for (int i = 0; i < 3; i++) begin
        side_b3.m[i]   <= m_b2[i];
        side_b3.nd[i]  <= nd_b2[i];
        side_b3.mir[i] <= mir_b2[i];
      end
      side_b3.nc   <= nc_b2;
      side_b3.cpos <= !c_b2[31];
      side_b3.tir  <= tir_b3;
    end
  end

  // ---------------- square root of k ----------------
  logic [vrt_pkg::ROOT_W-1:0] root;
  vrt_pkg::sq_side_t          side_s;

  vrt_sqrt #(
    .SIDE_W ($bits(vrt_pkg::sq_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_b3),
    .in_ready  (sq_in_ready),
    .rad       (rad_b3),
    .in_side   (side_b3),
    .out_valid (sq_out_valid),
    .out_ready (en_c1),
    .root      (root),
    .out_side  (side_s)
  );

  // ---------------- refracted direction and output ----------------
  logic signed [35:0] s_c, a_c;
  logic signed [35:0] a_c1;
  vrt_pkg::q_t  m_c1 [3];
  vrt_pkg::qw_t nd_c1 [3], nd_c2 [3];
  vrt_pkg::qr_t mir_c1 [3], mir_c2 [3], am_c2 [3];
  logic tir_c1, tir_c2;
  vrt_pkg::qr_t r_c [3];
  logic signed [47:0] y_c [3];
  logic signed [47:0] sat_c [3];

  // stage c1: a = sign(c) * sqrt(k) - n * c
  always_comb begin
    s_c = 36'(root);
    a_c = (side_s.cpos ? s_c : -s_c) - 36'($signed(side_s.nc));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c1 <= 1'b0;
    end else if (en_c1) begin
      v_c1 <= sq_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c1 && sq_out_valid) begin
      a_c1   <= a_c;
      tir_c1 <= side_s.tir;
      for (int i = 0; i < 3; i++) begin
        m_c1[i]   <= $signed(side_s.m[i]);
        nd_c1[i]  <= $signed(side_s.nd[i]);
        mir_c1[i] <= $signed(side_s.mir[i]);
      end
    end
  end

  // stage c2: a times the normal
  always_ff @(posedge clk) begin
    if (rst) begin
      v_c2 <= 1'b0;
    end else if (en_c2) begin
      v_c2 <= v_c1;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c2 && v_c1) begin
      tir_c2 <= tir_c1;
      for (int i = 0; i < 3; i++) begin
        am_c2[i]  <= 40'(mulq(a_c1, m_c1[i]));
        nd_c2[i]  <= nd_c1[i];
        mir_c2[i] <= mir_c1[i];
      end
    end
  end

  // stage c3: select, round to nearest (ties up), saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_c[i] = tir_c2 ? mir_c2[i] : 40'(nd_c2[i]) + am_c2[i];
      y_c[i] = ((48'(r_c[i]) + RND) >>> FL) <<< FR;
      priority if (y_c[i] > OUT_HI) begin
        sat_c[i] = OUT_HI;
      end else if (y_c[i] < OUT_LO) begin
        sat_c[i] = OUT_LO;
      end else begin
        sat_c[i] = y_c[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c3 <= 1'b0;
    end else if (en_c3) begin
      v_c3 <= v_c2;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c3 && v_c2) begin
      result.out_x            <= VEC_WIDTH'(sat_c[0]);
      result.out_y            <= VEC_WIDTH'(sat_c[1]);
      result.out_z            <= VEC_WIDTH'(sat_c[2]);
      result.total_reflection <= tir_c2;
    end
  end

  assign result.valid = v_c3;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int VW = 16;
  localparam int N_RANDOM = 600;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 120;

  // one ray item as offered to the block, plus a flag that makes the driver
  // wait until every expected result has come before offering it
  typedef struct {
    logic signed [VW-1:0]         rx, ry, rz;
    logic signed [VW-1:0]         nx, ny, nz;
    logic [vrt_pkg::IDX_W-1:0]    idx_from, idx_to;
    bit                           drain_first;
  } ray_item_t;

  typedef struct {
    logic signed [VW-1:0] ox, oy, oz;
    logic                 tir;
  } dir_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vrt_ray_if    #(.VEC_WIDTH(VW)) ray_bus ();
  vrt_result_if #(.VEC_WIDTH(VW)) res_bus ();

  vector_refraction_with_tir #(.VEC_WIDTH(VW)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .ray    (ray_bus),
    .result (res_bus)
  );

  always #5 clk = ~clk;

  ray_item_t pending_rays[$];
  dir_t      expected_dirs[$];
  int        mismatches = 0;
  int        rays_sent = 0;
  int        dirs_seen = 0;
  int        quiet_cycles = 0;
  bit        ray_took = 1'b0;
  bit        stim_done = 1'b0;

  // ---------------------------------------------------------------------------
  // fixed-point helpers for the predictor (Q.28 in 64 bits)
  // ---------------------------------------------------------------------------
  function automatic longint mul28(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> vrt_pkg::INT_FRAC;  // arithmetic shift floors
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned acc, bitv;
    acc = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= acc + bitv) begin
        v = v - (acc + bitv);
        acc = (acc >> 1) + bitv;
      end else begin
        acc = acc >> 1;
      end
      bitv = bitv >> 2;
    end
    return acc;
  endfunction

  // round to nearest (ties up) into Q1.14, then clamp to 16 bits
  function automatic logic signed [VW-1:0] to_vec(longint x);
    longint r;
    r = (x + (64'sd1 <<< (vrt_pkg::INT_FRAC - VW + 1))) >>> (vrt_pkg::INT_FRAC - VW + 2);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[VW-1:0];
  endfunction

  // snell refraction of one ray, mirror direction on total reflection
  function automatic dir_t refract_ray(ray_item_t it);
    longint d[3], m[3], o[3];
    longint cosv, ratio, disc, c2, root, coef;
    longint unsigned quo;
    bit tir;
    dir_t res;
    d[0] = longint'(it.rx) <<< (vrt_pkg::INT_FRAC - VW + 2);
    d[1] = longint'(it.ry) <<< (vrt_pkg::INT_FRAC - VW + 2);
    d[2] = longint'(it.rz) <<< (vrt_pkg::INT_FRAC - VW + 2);
    m[0] = longint'(it.nx) <<< (vrt_pkg::INT_FRAC - VW + 2);
    m[1] = longint'(it.ny) <<< (vrt_pkg::INT_FRAC - VW + 2);
    m[2] = longint'(it.nz) <<< (vrt_pkg::INT_FRAC - VW + 2);
    cosv = 0;
    for (int i = 0; i < 3; i++) cosv += mul28(d[i], m[i]);
    // non-unit vectors: cosine clamped to +-2
    if (cosv > 2 * vrt_pkg::Q_ONE) cosv = 2 * vrt_pkg::Q_ONE;
    if (cosv < -2 * vrt_pkg::Q_ONE) cosv = -2 * vrt_pkg::Q_ONE;
    // index ratio, clamped to 4.0; a zero divisor gives 4.0 as well
    if (it.idx_to == 0) begin
      ratio = 4 * vrt_pkg::Q_ONE;
    end else begin
      quo = (longint'(it.idx_from) << vrt_pkg::INT_FRAC) / longint'(it.idx_to);
      if (quo > 4 * vrt_pkg::Q_ONE) quo = 4 * vrt_pkg::Q_ONE;
      ratio = quo;
    end
    disc = 0;
    tir = (cosv == 0);
    if (!tir) begin
      c2 = mul28(cosv, cosv);
      disc = vrt_pkg::Q_ONE - mul28(mul28(ratio, ratio), vrt_pkg::Q_ONE - c2);
      tir = (disc <= 0);
    end
    if (tir) begin
      for (int i = 0; i < 3; i++) o[i] = d[i] - mul28(2 * cosv, m[i]);
    end else begin
      root = root64(longint'(disc) << vrt_pkg::INT_FRAC);
      coef = (cosv > 0 ? root : -root) - mul28(ratio, cosv);
      for (int i = 0; i < 3; i++) o[i] = mul28(ratio, d[i]) + mul28(coef, m[i]);
    end
    res.ox = to_vec(o[0]);
    res.oy = to_vec(o[1]);
    res.oz = to_vec(o[2]);
    res.tir = tir;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus construction
  // ---------------------------------------------------------------------------
  function automatic logic signed [VW-1:0] q14(real r);
    real s;
    s = r * 16384.0;
    if (s > 32767.0) s = 32767.0;
    if (s < -32768.0) s = -32768.0;
    return VW'($rtoi(s));
  endfunction

  task automatic add_ray(int rx, int ry, int rz, int nx, int ny, int nz,
                         int n_from, int n_to, bit drain = 1'b0);
    ray_item_t it;
    it.rx = VW'(rx); it.ry = VW'(ry); it.rz = VW'(rz);
    it.nx = VW'(nx); it.ny = VW'(ny); it.nz = VW'(nz);
    it.idx_from = vrt_pkg::IDX_W'(n_from); it.idx_to = vrt_pkg::IDX_W'(n_to);
    it.drain_first = drain;
    pending_rays.push_back(it);
  endtask

  // random unit vector
  task automatic unit_vec(output logic signed [VW-1:0] vx, vy, vz);
    real x, y, z, len;
    x = ($itor($urandom_range(0, 20000)) - 10000.0) / 10000.0;
    y = ($itor($urandom_range(0, 20000)) - 10000.0) / 10000.0;
    z = ($itor($urandom_range(0, 20000)) - 10000.0) / 10000.0;
    len = $sqrt(x * x + y * y + z * z);
    if (len < 0.01) begin
      x = 0.0; y = 0.0; z = 1.0; len = 1.0;
    end
    vx = q14(x / len);
    vy = q14(y / len);
    vz = q14(z / len);
  endtask

  task automatic add_random_ray(bit drain);
    ray_item_t it;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      // well-formed: unit vectors, indices in the physical range
      unit_vec(it.rx, it.ry, it.rz);
      unit_vec(it.nx, it.ny, it.nz);
      if ($urandom_range(0, 3) == 0) begin
        // common media pairs make total reflection frequent
        it.idx_from = vrt_pkg::IDX_W'($urandom_range(5900, 10000));
        it.idx_to = vrt_pkg::IDX_W'($urandom_range(4096, 5500));
      end else begin
        it.idx_from = vrt_pkg::IDX_W'($urandom_range(4096, 16383));
        it.idx_to = vrt_pkg::IDX_W'($urandom_range(4096, 16383));
      end
    end else begin
      // raw noise over every bit of every field
      it.rx = VW'($urandom); it.ry = VW'($urandom); it.rz = VW'($urandom);
      it.nx = VW'($urandom); it.ny = VW'($urandom); it.nz = VW'($urandom);
      it.idx_from = vrt_pkg::IDX_W'($urandom);
      it.idx_to = vrt_pkg::IDX_W'($urandom);
    end
    it.drain_first = drain;
    pending_rays.push_back(it);
  endtask

  initial begin
    // directed: normal incidence, equal media
    add_ray(0, 0, 16384, 0, 0, 16384, 4096, 4096);
    // zero cosine: ray in the plane of the face
    add_ray(16384, 0, 0, 0, 0, 16384, 4096, 6144);
    // oblique into denser medium, and back out past the critical angle
    add_ray(11585, 0, -11585, 0, 0, 16384, 4096, 6144);
    add_ray(13000, 0, -9970, 0, 0, -16384, 6144, 4096);
    add_ray(15000, 0, 6590, 0, 0, 16384, 16383, 4096);
    // large ratio saturated to 4.0, and a zero index_to
    add_ray(2000, 0, 16261, 0, 0, 16384, 16383, 1);
    add_ray(0, 0, 16384, 0, 0, 16384, 16383, 0);
    add_ray(0, 0, -16384, 0, 0, 16384, 0, 0);
    add_ray(100, 0, 16384, 0, 0, 16384, 0, 16383);
    // field extremes, non-unit vectors with clamped cosine
    add_ray(-32768, -32768, -32768, -32768, -32768, -32768, 16383, 16383);
    add_ray(32767, 32767, 32767, 32767, 32767, 32767, 4096, 16383);
    add_ray(32767, -32768, 32767, -32768, 32767, -32768, 16383, 4096);
    add_ray(-32768, 0, 0, 32767, 0, 0, 4096, 4096);
    // tiny cosine, both signs
    add_ray(16384, 0, 1, 0, 0, 16384, 4096, 4096);
    add_ray(16384, 0, -1, 0, 0, 16384, 4096, 4096);
    // outputs that saturate, and tiny vectors with near-equal indices
    add_ray(32767, 32767, 0, 32767, 32767, 0, 16383, 4096);
    add_ray(-32768, -32768, 0, 32767, 32767, 0, 4096, 16383);
    add_ray(1, -1, 1, -1, 1, -1, 8191, 8192);

    for (int i = 0; i < N_RANDOM; i++) add_random_ray(i == 450);
    stim_done = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // reset
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // ray driver: changes at the falling edge; items 200..299 go without gaps
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      ray_bus.valid <= 1'b0;
      ray_bus.ray_x <= '0;
      ray_bus.ray_y <= '0;
      ray_bus.ray_z <= '0;
      ray_bus.normal_x <= '0;
      ray_bus.normal_y <= '0;
      ray_bus.normal_z <= '0;
      ray_bus.index_from <= '0;
      ray_bus.index_to <= '0;
    end else if (!ray_bus.valid || ray_took) begin
      if (pending_rays.size() == 0) begin
        ray_bus.valid <= 1'b0;
      end else if (pending_rays[0].drain_first && expected_dirs.size() != 0) begin
        // pause until the pipe has emptied
        ray_bus.valid <= 1'b0;
      end else if (!(rays_sent >= 200 && rays_sent < 300) && $urandom_range(0, 99) < 21) begin
        ray_bus.valid <= 1'b0;
      end else begin
        ray_item_t it;
        it = pending_rays.pop_front();
        ray_bus.valid <= 1'b1;
        ray_bus.ray_x <= it.rx;
        ray_bus.ray_y <= it.ry;
        ray_bus.ray_z <= it.rz;
        ray_bus.normal_x <= it.nx;
        ray_bus.normal_y <= it.ny;
        ray_bus.normal_z <= it.nz;
        ray_bus.index_from <= it.idx_from;
        ray_bus.index_to <= it.idx_to;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stalls, one long hold-off once results flow
  // ---------------------------------------------------------------------------
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_bus.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && dirs_seen >= 300) begin
      // the sender keeps offering, so the pipe fills and stalls its input
      res_bus.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (dirs_seen >= 200 && dirs_seen < 300) begin
      res_bus.ready <= 1'b1;
    end else begin
      res_bus.ready <= ($urandom_range(0, 99) >= 21);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: sample at the rising edge, predict on input, compare on output
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      ray_took <= 1'b0;
    end else begin
      ray_took <= ray_bus.valid && ray_bus.ready;
      if (ray_bus.valid && ray_bus.ready) begin
        ray_item_t it;
        it.rx = ray_bus.ray_x; it.ry = ray_bus.ray_y; it.rz = ray_bus.ray_z;
        it.nx = ray_bus.normal_x; it.ny = ray_bus.normal_y; it.nz = ray_bus.normal_z;
        it.idx_from = ray_bus.index_from;
        it.idx_to = ray_bus.index_to;
        it.drain_first = 1'b0;
        expected_dirs.push_back(refract_ray(it));
        rays_sent <= rays_sent + 1;
      end
      if (res_bus.valid && res_bus.ready) begin
        dirs_seen <= dirs_seen + 1;
        if (expected_dirs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result at %0t: out=(%0d,%0d,%0d) tir=%0b", $realtime,
                     res_bus.out_x, res_bus.out_y, res_bus.out_z, res_bus.total_reflection);
        end else begin
          dir_t e;
          e = expected_dirs.pop_front();
          if (res_bus.out_x !== e.ox || res_bus.out_y !== e.oy || res_bus.out_z !== e.oz ||
              res_bus.total_reflection !== e.tir) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at %0t: expected (%0d,%0d,%0d) tir=%0b, got (%0d,%0d,%0d) %s%0b",
                       $realtime, e.ox, e.oy, e.oz, e.tir, res_bus.out_x, res_bus.out_y,
                       res_bus.out_z, "tir=", res_bus.total_reflection);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: cycles with no item moving on either side
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (ray_bus.valid && ray_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** vector_refraction_with_tir: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // end of run
  // ---------------------------------------------------------------------------
  initial begin
    wait (stim_done);
    // valid is stable at the rising edge, so the last item is never missed
    @(posedge clk);
    while (pending_rays.size() != 0 || ray_bus.valid || expected_dirs.size() != 0)
      @(posedge clk);
    // let a stray result, if any, show up
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_dirs.size() == 0)
      $display("** vector_refraction_with_tir: PASSED **");
    else
      $display("** vector_refraction_with_tir: FAILED **");
    $finish;
  end

endmodule

### vector_refraction_with_tir.f
hdl/vrt_pkg.sv
hdl/vrt_if.sv
hdl/vrt_div.sv
hdl/vrt_sqrt.sv
hdl/vector_refraction_with_tir.sv
test/tb_top.sv
